FILE: hw/rtl/ccs_pkg.sv
// Package for the contour corner splitter: widths, constants, codes and
// the controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps

package ccs_pkg;

  // Fixed sizes of the block.
  localparam int MAX_POINTS = 4096;
  localparam int MAX_WINDOW = 16;
  localparam int COORD_BITS = 11;
  localparam int DEPTH      = 2 * MAX_WINDOW + 1;

  localparam int COORD_W = 11;
  localparam int IDX_W   = 13;
  localparam int ID_W    = 16;
  localparam int COS_W   = 17;
  localparam int WIN_W   = 5;
  localparam int ADDR_W  = 6;
  localparam int CFG_W   = 17;
  localparam int CFGI_W  = 2;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int NORM_W  = 23;
  localparam int DOT_W   = 24;
  localparam int MUL_W   = 25;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SQ_W    = 2 * NORM_W;
  localparam int PART_W  = COS_W + NORM_W;
  localparam int CMP_W   = SQ_W + COS_W;

  localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((1 << COORD_BITS) - 1);
  localparam logic [IDX_W-1:0]   IDX_MAX    = IDX_W'(MAX_POINTS);
  localparam logic [ID_W-1:0]    ID_MAX     = '1;

  // Configuration register indexes.
  localparam logic [CFGI_W-1:0] CFG_COS_SQ  = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_MIN_LEN = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_WINDOW  = 2'd2;

  localparam logic [COS_W-1:0] COS_RESET     = 17'd49152;
  localparam logic [IDX_W-1:0] MIN_LEN_RESET = 13'd10;
  localparam logic [WIN_W-1:0] WINDOW_RESET  = 5'd3;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_AXX,
    ST_AYY,
    ST_BXX,
    ST_BYY,
    ST_DOTX,
    ST_DOTY,
    ST_DSQ,
    ST_NN,
    ST_CLO,
    ST_CHI,
    ST_CMP,
    ST_DECIDE,
    ST_PUSH_BRK,
    ST_PUSH_CLS
  } ccs_state_t;

  // Operation of the shared multiplier.
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_AXX,
    MUL_AYY,
    MUL_BXX,
    MUL_BYY,
    MUL_DOTX,
    MUL_DOTY,
    MUL_DSQ,
    MUL_NN,
    MUL_CLO,
    MUL_CHI
  } ccs_mul_op_t;

  typedef struct packed {
    logic        load;
    logic        diff;
    ccs_mul_op_t mul;
    logic        cmp;
    logic        decide;
    logic        push_brk;
    logic        push_cls;
  } ccs_cmd_t;

  typedef struct packed {
    logic test;
    logic emit_brk;
    logic emit_cls;
    logic out_free;
  } ccs_stat_t;

  // Window register as used: zero acts as one, large values clamp.
  function automatic logic [WIN_W-1:0] clamp_window(input logic [WIN_W-1:0] w);
    logic [WIN_W-1:0] r;
    r = w;
    if (w == '0) begin
      r = WIN_W'(1);
    end else if (w > WIN_W'(MAX_WINDOW)) begin
      r = WIN_W'(MAX_WINDOW);
    end
    return r;
  endfunction

  // Delay-line address d places behind the write pointer, modulo DEPTH.
  function automatic logic [ADDR_W-1:0] wrap_sub(input logic [ADDR_W-1:0] p,
                                                 input logic [ADDR_W-1:0] d);
    logic [ADDR_W:0] t;
    t = {1'b0, p} - {1'b0, d};
    if (t[ADDR_W]) begin
      t = t + (ADDR_W + 1)'(DEPTH);
    end
    return t[ADDR_W-1:0];
  endfunction

  // A segment [a, b) is reported when it holds at least min_len points.
  // An end below the start wraps to a huge length and always qualifies.
  function automatic logic long_enough(input logic [IDX_W-1:0] a,
                                       input logic [IDX_W-1:0] b,
                                       input logic [IDX_W-1:0] min_len);
    logic [IDX_W-1:0] d;
    d = b - a;
    return (b < a) || (d >= min_len);
  endfunction

endpackage

FILE: hw/rtl/ccs_if.sv
// Valid/ready channel interfaces for point words and segment words.
// Depends on ccs_pkg for field widths.
`timescale 1ns / 1ps

interface ccs_in_if;
  logic                         valid;
  logic                         ready;
  logic [ccs_pkg::COORD_W-1:0]  point_x;
  logic [ccs_pkg::COORD_W-1:0]  point_y;
  logic                         last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface ccs_out_if;
  logic                       valid;
  logic                       ready;
  logic [ccs_pkg::IDX_W-1:0]  seg_start;
  logic [ccs_pkg::IDX_W-1:0]  seg_end;
  logic [ccs_pkg::ID_W-1:0]   seg_id;
  logic                       contour_end;
  logic                       run_last;

  modport source (output valid, seg_start, seg_end, seg_id, contour_end, run_last,
                  input ready);
  modport sink   (input valid, seg_start, seg_end, seg_id, contour_end, run_last,
                  output ready);
endinterface

FILE: hw/rtl/ccs_ctrl.sv
// Controller of the contour corner splitter: sequences load, difference,
// the multiply steps, the compare and the segment pushes. Uses ccs_pkg.
`timescale 1ns / 1ps

module ccs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ccs_pkg::ccs_stat_t stat,
  output ccs_pkg::ccs_cmd_t  cmd
);
  import ccs_pkg::*;

  ccs_state_t state_r;
  ccs_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        state_nxt = stat.test ? ST_AXX : ST_DECIDE;
      end
      ST_AXX:    state_nxt = ST_AYY;
      ST_AYY:    state_nxt = ST_BXX;
      ST_BXX:    state_nxt = ST_BYY;
      ST_BYY:    state_nxt = ST_DOTX;
      ST_DOTX:   state_nxt = ST_DOTY;
      ST_DOTY:   state_nxt = ST_DSQ;
      ST_DSQ:    state_nxt = ST_NN;
      ST_NN:     state_nxt = ST_CLO;
      ST_CLO:    state_nxt = ST_CHI;
      ST_CHI:    state_nxt = ST_CMP;
      ST_CMP:    state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        state_nxt = ST_PUSH_BRK;
      end
      ST_PUSH_BRK: begin
        if (!stat.emit_brk) begin
          state_nxt = ST_PUSH_CLS;
        end else if (stat.out_free) begin
          state_nxt = ST_PUSH_CLS;
        end
      end
      ST_PUSH_CLS: begin
        if (!stat.emit_cls || stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    cmd.mul  = MUL_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DIFF:     cmd.diff     = 1'b1;
      ST_AXX:      cmd.mul      = MUL_AXX;
      ST_AYY:      cmd.mul      = MUL_AYY;
      ST_BXX:      cmd.mul      = MUL_BXX;
      ST_BYY:      cmd.mul      = MUL_BYY;
      ST_DOTX:     cmd.mul      = MUL_DOTX;
      ST_DOTY:     cmd.mul      = MUL_DOTY;
      ST_DSQ:      cmd.mul      = MUL_DSQ;
      ST_NN:       cmd.mul      = MUL_NN;
      ST_CLO:      cmd.mul      = MUL_CLO;
      ST_CHI:      cmd.mul      = MUL_CHI;
      ST_CMP:      cmd.cmp      = 1'b1;
      ST_DECIDE:   cmd.decide   = 1'b1;
      ST_PUSH_BRK: cmd.push_brk = stat.emit_brk && stat.out_free;
      ST_PUSH_CLS: cmd.push_cls = stat.emit_cls && stat.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/ccs_datapath.sv
// Datapath of the contour corner splitter: point delay line, shared
// multiplier, corner compare, segment bookkeeping and output register.
// Uses ccs_pkg; driven by ccs_ctrl commands.
`timescale 1ns / 1ps

module ccs_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input word
  input  logic [ccs_pkg::COORD_W-1:0]  point_x,
  input  logic [ccs_pkg::COORD_W-1:0]  point_y,
  input  logic                         last_point,
  // Configuration writes
  input  logic                         cfg_we,
  input  logic [ccs_pkg::CFGI_W-1:0]   cfg_index,
  input  logic [ccs_pkg::CFG_W-1:0]    cfg_wdata,
  // Controller link
  input  ccs_pkg::ccs_cmd_t            cmd,
  output ccs_pkg::ccs_stat_t           stat,
  // Result word
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ccs_pkg::IDX_W-1:0]    seg_start,
  output logic [ccs_pkg::IDX_W-1:0]    seg_end,
  output logic [ccs_pkg::ID_W-1:0]     seg_id,
  output logic                         contour_end,
  output logic                         run_last
);
  import ccs_pkg::*;

  // Configuration registers.
  logic [COS_W-1:0] cos_sq_r;
  logic [IDX_W-1:0] min_len_r;
  logic [WIN_W-1:0] window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_sq_r  <= COS_RESET;
      min_len_r <= MIN_LEN_RESET;
      window_r  <= WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COS_SQ:  cos_sq_r  <= cfg_wdata[COS_W-1:0];
        CFG_MIN_LEN: min_len_r <= cfg_wdata[IDX_W-1:0];
        CFG_WINDOW:  window_r  <= cfg_wdata[WIN_W-1:0];
        default:     cos_sq_r  <= cos_sq_r;
      endcase
    end
  end

  // Contour state.
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  start_r;
  logic [ID_W-1:0]   count_r;
  logic [ADDR_W-1:0] wp_r;

  // Per-word registers latched at load.
  logic [WIN_W-1:0]   w_r;
  logic               test_r;
  logic               last_r;
  logic [COORD_W-1:0] cur_x_r;
  logic [COORD_W-1:0] cur_y_r;

  // Window as used and the read addresses of the two older points.
  logic [WIN_W-1:0]  w_eff;
  logic [ADDR_W-1:0] w_dist;
  logic [ADDR_W-1:0] w2_dist;
  logic              in_range;
  logic [COORD_W-1:0] x_in;
  logic [COORD_W-1:0] y_in;

  assign w_eff    = clamp_window(window_r);
  assign w_dist   = ADDR_W'(w_eff);
  assign w2_dist  = {w_eff, 1'b0};
  assign in_range = idx_r < IDX_MAX;
  assign x_in     = point_x & COORD_MASK;
  assign y_in     = point_y & COORD_MASK;

  // Point delay line: per load, one write (for an index in range) and two reads.
  logic [2*COORD_W-1:0] mem [DEPTH];
  logic [2*COORD_W-1:0] mid_q;
  logic [2*COORD_W-1:0] old_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (in_range) begin
        mem[wp_r] <= {y_in, x_in};
      end
      mid_q <= mem[wrap_sub(wp_r, w_dist)];
      old_q <= mem[wrap_sub(wp_r, w2_dist)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r     <= w_eff;
      test_r  <= in_range && (idx_r >= IDX_W'(w2_dist));
      last_r  <= last_point;
      cur_x_r <= x_in;
      cur_y_r <= y_in;
    end
  end

  // Direction vectors: a from the old point to the middle one, b onward.
  logic signed [DIFF_W-1:0] ax_r;
  logic signed [DIFF_W-1:0] ay_r;
  logic signed [DIFF_W-1:0] bx_r;
  logic signed [DIFF_W-1:0] by_r;

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      ax_r <= signed'({1'b0, mid_q[COORD_W-1:0]}) - signed'({1'b0, old_q[COORD_W-1:0]});
      ay_r <= signed'({1'b0, mid_q[2*COORD_W-1:COORD_W]})
            - signed'({1'b0, old_q[2*COORD_W-1:COORD_W]});
      bx_r <= signed'({1'b0, cur_x_r}) - signed'({1'b0, mid_q[COORD_W-1:0]});
      by_r <= signed'({1'b0, cur_y_r}) - signed'({1'b0, mid_q[2*COORD_W-1:COORD_W]});
    end
  end

  // Shared multiplier and its accumulators.
  logic [NORM_W-1:0]        n1_r;
  logic [NORM_W-1:0]        n2_r;
  logic signed [DOT_W-1:0]  dot_r;
  logic [SQ_W-1:0]          dsq_r;
  logic [SQ_W-1:0]          nn_r;
  logic [PART_W-1:0]        lo_r;
  logic [PART_W-1:0]        hi_r;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [DOT_W-1:0]         dot_neg;
  logic [NORM_W-1:0]        dot_abs;

  assign dot_neg = -dot_r;
  assign dot_abs = dot_r[DOT_W-1] ? dot_neg[NORM_W-1:0] : dot_r[NORM_W-1:0];

  // Operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul)
      MUL_AXX: begin
        mul_a = MUL_W'(ax_r);
        mul_b = MUL_W'(ax_r);
      end
      MUL_AYY: begin
        mul_a = MUL_W'(ay_r);
        mul_b = MUL_W'(ay_r);
      end
      MUL_BXX: begin
        mul_a = MUL_W'(bx_r);
        mul_b = MUL_W'(bx_r);
      end
      MUL_BYY: begin
        mul_a = MUL_W'(by_r);
        mul_b = MUL_W'(by_r);
      end
      MUL_DOTX: begin
        mul_a = MUL_W'(ax_r);
        mul_b = MUL_W'(bx_r);
      end
      MUL_DOTY: begin
        mul_a = MUL_W'(ay_r);
        mul_b = MUL_W'(by_r);
      end
      MUL_DSQ: begin
        mul_a = signed'({2'b00, dot_abs});
        mul_b = signed'({2'b00, dot_abs});
      end
      MUL_NN: begin
        mul_a = signed'({2'b00, n1_r});
        mul_b = signed'({2'b00, n2_r});
      end
      MUL_CLO: begin
        mul_a = signed'({{(MUL_W-COS_W){1'b0}}, cos_sq_r});
        mul_b = signed'({2'b00, nn_r[NORM_W-1:0]});
      end
      MUL_CHI: begin
        mul_a = signed'({{(MUL_W-COS_W){1'b0}}, cos_sq_r});
        mul_b = signed'({2'b00, nn_r[SQ_W-1:NORM_W]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Product registers, one step per cycle.
  always_ff @(posedge clk) begin
    case (cmd.mul)
      MUL_AXX:  n1_r  <= mul_p[NORM_W-1:0];
      MUL_AYY:  n1_r  <= n1_r + mul_p[NORM_W-1:0];
      MUL_BXX:  n2_r  <= mul_p[NORM_W-1:0];
      MUL_BYY:  n2_r  <= n2_r + mul_p[NORM_W-1:0];
      MUL_DOTX: dot_r <= mul_p[DOT_W-1:0];
      MUL_DOTY: dot_r <= dot_r + mul_p[DOT_W-1:0];
      MUL_DSQ:  dsq_r <= mul_p[SQ_W-1:0];
      MUL_NN:   nn_r  <= mul_p[SQ_W-1:0];
      MUL_CLO:  lo_r  <= mul_p[PART_W-1:0];
      MUL_CHI:  hi_r  <= mul_p[PART_W-1:0];
      default:  lo_r  <= lo_r;
    endcase
  end

  // Corner compare: dot^2 * 2^16 against cos^2 * |a|^2 * |b|^2; a zero-length vector is a corner if cos^2 is nonzero.
  logic [CMP_W-1:0] lhs;
  logic [CMP_W-1:0] rhs;
  logic             corner_r;

  assign lhs = {1'b0, dsq_r, 16'b0};
  assign rhs = {hi_r, {NORM_W{1'b0}}} + CMP_W'(lo_r);

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      if (n1_r == '0 || n2_r == '0) begin
        corner_r <= cos_sq_r != '0;
      end else begin
        corner_r <= lhs < rhs;
      end
    end
  end

  // Segment decision for the word.
  logic [IDX_W-1:0] center;
  logic [IDX_W-1:0] len;
  logic             brk;
  logic [IDX_W-1:0] new_start;

  assign center    = idx_r - IDX_W'(w_r);
  assign len       = in_range ? idx_r + IDX_W'(1) : IDX_MAX;
  assign brk       = test_r && corner_r;
  assign new_start = brk ? center : start_r;

  logic             emit_brk_r;
  logic             emit_cls_r;
  logic [IDX_W-1:0] brk_start_r;
  logic [IDX_W-1:0] brk_end_r;
  logic [IDX_W-1:0] cls_start_r;
  logic [IDX_W-1:0] cls_end_r;

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      brk_start_r <= start_r;
      brk_end_r   <= center;
      cls_start_r <= new_start;
      cls_end_r   <= len;
    end
  end

  // Contour bookkeeping and emit flags.
  logic out_valid_r;
  logic out_free;
  logic push;

  assign out_free = !out_valid_r || out_ready;
  assign push     = cmd.push_brk || cmd.push_cls;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      start_r    <= '0;
      wp_r       <= '0;
      count_r    <= '0;
      emit_brk_r <= 1'b0;
      emit_cls_r <= 1'b0;
    end else begin
      if (cmd.decide) begin
        emit_brk_r <= brk && long_enough(start_r, center, min_len_r);
        emit_cls_r <= last_r && (len >= IDX_W'(3))
                      && long_enough(new_start, len, min_len_r);
        if (last_r) begin
          idx_r   <= '0;
          start_r <= '0;
          wp_r    <= '0;
        end else begin
          idx_r   <= len;
          start_r <= new_start;
          if (in_range) begin
            wp_r <= (wp_r == ADDR_W'(DEPTH - 1)) ? '0 : wp_r + ADDR_W'(1);
          end
        end
      end
      if (push && count_r != ID_MAX) begin
        count_r <= count_r + ID_W'(1);
      end
    end
  end

  // Output register.
  logic [IDX_W-1:0] seg_start_r;
  logic [IDX_W-1:0] seg_end_r;
  logic [ID_W-1:0]  seg_id_r;
  logic             contour_end_r;
  logic             run_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_brk) begin
      seg_start_r   <= brk_start_r;
      seg_end_r     <= brk_end_r;
      seg_id_r      <= count_r;
      contour_end_r <= 1'b0;
      run_last_r    <= !emit_cls_r;
    end else if (cmd.push_cls) begin
      seg_start_r   <= cls_start_r;
      seg_end_r     <= cls_end_r;
      seg_id_r      <= count_r;
      contour_end_r <= 1'b1;
      run_last_r    <= 1'b1;
    end
  end

  // Status to the controller.
  always_comb begin
    stat.test     = test_r;
    stat.emit_brk = emit_brk_r;
    stat.emit_cls = emit_cls_r;
    stat.out_free = out_free;
  end

  assign out_valid   = out_valid_r;
  assign seg_start   = seg_start_r;
  assign seg_end     = seg_end_r;
  assign seg_id      = seg_id_r;
  assign contour_end = contour_end_r;
  assign run_last    = run_last_r;

endmodule

FILE: hw/rtl/contour_corner_splitter.sv
// Contour corner splitter: splits contour point words into segment words at sharp turns.
// Each accepted point word passes through load, difference, ten multiply steps, compare, decide
// and two push slots; without a corner test the multiply steps and the compare are skipped.
// A push slot waits while the output register still holds a segment word not yet taken.
// A new point word is accepted only once the previous one has left its push slots.
// Synchronous reset (rst_n low) clears counters, loads defaults; the delay line is kept.
`timescale 1ns / 1ps

module contour_corner_splitter (
  input  logic                       clk,
  input  logic                       rst_n,
  ccs_in_if.sink                     in_ch,
  ccs_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [ccs_pkg::CFGI_W-1:0] cfg_index,
  input  logic [ccs_pkg::CFG_W-1:0]  cfg_wdata
);
  import ccs_pkg::*;

  ccs_cmd_t  cmd;
  ccs_stat_t stat;

  // Sequencer.
  ccs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic and storage.
  ccs_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .point_x     (in_ch.point_x),
    .point_y     (in_ch.point_y),
    .last_point  (in_ch.last_point),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .seg_start   (out_ch.seg_start),
    .seg_end     (out_ch.seg_end),
    .seg_id      (out_ch.seg_id),
    .contour_end (out_ch.contour_end),
    .run_last    (out_ch.run_last)
  );

endmodule

FILE: tb/tb.sv
// Testbench for contour_corner_splitter: drives point words, predicts the segment words
// with its own corner model and checks every accepted segment word field by field.
// Depends on ccs_pkg, the ccs_in_if/ccs_out_if interfaces and the block itself.
`timescale 1ns / 1ps

module tb;
  import ccs_pkg::*;

  localparam logic [CFGI_W-1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_POINTS = 520;
  localparam int STILL_POINTS  = 60;
  localparam int ID_LIMIT      = 65535;

  typedef enum int {SHAPE_PATH, SHAPE_NOISE, SHAPE_STILL} contour_shape_t;

  typedef struct {
    logic [IDX_W-1:0] start_idx;
    logic [IDX_W-1:0] end_idx;
    logic [ID_W-1:0]  id;
    logic             closing;
    logic             tail;
  } seg_word_t;

  // Segment predictor and the queue of segment words still owed by the block.
  class seg_scoreboard_t;
    logic [2*COORD_W-1:0] trail [DEPTH];
    int unsigned next_idx;
    int unsigned open_from;
    int unsigned seg_total;
    int unsigned cos_thr;
    int unsigned min_len;
    int unsigned win_reg;
    seg_word_t   pending [$];
    int          err_count;

    function new();
      next_idx  = 0;
      open_from = 0;
      seg_total = 0;
      // Register defaults after reset.
      cos_thr   = 49152;
      min_len   = 10;
      win_reg   = 3;
      err_count = 0;
    endfunction

    task report_mismatch(string what);
      err_count++;
      if (err_count <= 40) begin
        $display("MISMATCH at %0t: %s", $time, what);
      end
    endtask

    function void set_reg(logic [CFGI_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_COS_SQ:  cos_thr = data;
        CFG_MIN_LEN: min_len = data[12:0];
        CFG_WINDOW:  win_reg = data[4:0];
        default: ;
      endcase
    endfunction

    function longint coord(int unsigned idx, bit want_y);
      logic [2*COORD_W-1:0] w;
      w = trail[idx % DEPTH];
      return want_y ? longint'(w[21:11]) : longint'(w[10:0]);
    endfunction

    // Corner test in integer form: dot^2 * 2^16 < cos_thr * |v1|^2 * |v2|^2.
    function bit sharp_turn(int unsigned c, int unsigned w);
      longint          ax, ay, bx, by, dot;
      longint unsigned n1, n2, ad, lhs, rhs;
      ax = coord(c, 1'b0) - coord(c - w, 1'b0);
      ay = coord(c, 1'b1) - coord(c - w, 1'b1);
      bx = coord(c + w, 1'b0) - coord(c, 1'b0);
      by = coord(c + w, 1'b1) - coord(c, 1'b1);
      n1 = ax * ax + ay * ay;
      n2 = bx * bx + by * by;
      dot = ax * bx + ay * by;
      ad = (dot < 0) ? -dot : dot;
      // A zero-length vector counts as cosine zero.
      if (n1 == 0 || n2 == 0) begin
        return cos_thr > 0;
      end
      lhs = ad * ad * 64'd65536;
      rhs = 64'(cos_thr) * n1 * n2;
      return lhs < rhs;
    endfunction

    // Queues segment [a, b) if it is long enough; an end below the start wraps
    // to a huge length and always qualifies.
    function int add_segment(int unsigned a, int unsigned b, bit closing);
      seg_word_t s;
      if (b - a < min_len) begin
        return 0;
      end
      s.start_idx = a[12:0];
      s.end_idx   = b[12:0];
      s.id        = seg_total[15:0];
      s.closing   = closing;
      s.tail      = 1'b0;
      pending = {pending, s};
      if (seg_total < ID_LIMIT) begin
        seg_total++;
      end
      return 1;
    endfunction

    function void note_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, bit is_last);
      int unsigned w, i, c, span;
      int          made;
      w = win_reg;
      if (w < 1) w = 1;
      if (w > MAX_WINDOW) w = MAX_WINDOW;
      i = next_idx;
      made = 0;
      // Points past the index limit are dropped and cause no corner test.
      if (i < MAX_POINTS) begin
        trail[i % DEPTH] = {y, x};
        if (i >= 2 * w) begin
          c = i - w;
          if (sharp_turn(c, w)) begin
            made += add_segment(open_from, c, 1'b0);
            open_from = c;
          end
        end
        span = i + 1;
      end else begin
        span = MAX_POINTS;
      end
      next_idx = span;
      // Contours shorter than three points report nothing.
      if (is_last) begin
        if (span >= 3) begin
          made += add_segment(open_from, span, 1'b1);
        end
        next_idx  = 0;
        open_from = 0;
      end
      if (made > 0) begin
        pending[pending.size() - 1].tail = 1'b1;
      end
    endfunction

    task check_segment(logic [IDX_W-1:0] start_idx, logic [IDX_W-1:0] end_idx,
                       logic [ID_W-1:0] id, logic closing, logic tail);
      seg_word_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected segment word [%0d,%0d) id %0d",
                                  start_idx, end_idx, id));
        return;
      end
      e = pending.pop_front();
      if (start_idx !== e.start_idx)
        report_mismatch($sformatf("seg_start %0d, expected %0d", start_idx, e.start_idx));
      if (end_idx !== e.end_idx)
        report_mismatch($sformatf("seg_end %0d, expected %0d", end_idx, e.end_idx));
      if (id !== e.id)
        report_mismatch($sformatf("seg_id %0d, expected %0d", id, e.id));
      if (closing !== e.closing)
        report_mismatch($sformatf("contour_end %0b, expected %0b", closing, e.closing));
      if (tail !== e.tail)
        report_mismatch($sformatf("run_last %0b, expected %0b", tail, e.tail));
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFGI_W-1:0]   cfg_index;
  logic [CFG_W-1:0]    cfg_wdata;
  bit                  idle_on = 1'b1;
  int                  hold_left = 0;
  int                  points_sent = 0;
  seg_scoreboard_t     board;

  ccs_in_if  in_ch ();
  ccs_out_if out_ch ();

  contour_corner_splitter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard time limit for the whole run.
  initial begin : watchdog
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Segment word sink: checks accepted words, stalls at random or for a long hold-off.
  initial begin : segment_sink
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        board.check_segment(out_ch.seg_start, out_ch.seg_end, out_ch.seg_id,
                            out_ch.contour_end, out_ch.run_last);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(idle_on && $urandom_range(99) < 15);
      end
    end
  end

  // Offers one point word and returns at the edge where it is accepted.
  task automatic send_point(input int x, input int y, input bit is_last);
    if (idle_on && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(20, 1)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.point_x    <= x[10:0];
    in_ch.point_y    <= y[10:0];
    in_ch.last_point <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_point(x[10:0], y[10:0], is_last);
    points_sent++;
  endtask

  // Stops offering, waits for every owed segment word, then lets the block go quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all registers while the block is idle; unused bits carry random data.
  task automatic program_regs(input logic [16:0] cos, input logic [12:0] minl,
                              input logic [4:0] win);
    logic [CFG_W-1:0] d;
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COS_SQ;
    cfg_wdata <= cos;
    @(posedge clk);
    board.set_reg(CFG_COS_SQ, cos);
    d = CFG_W'($urandom);
    d[12:0] = minl;
    cfg_index <= CFG_MIN_LEN;
    cfg_wdata <= d;
    @(posedge clk);
    board.set_reg(CFG_MIN_LEN, d);
    d = CFG_W'($urandom);
    d[4:0] = win;
    cfg_index <= CFG_WINDOW;
    cfg_wdata <= d;
    @(posedge clk);
    board.set_reg(CFG_WINDOW, d);
    // The spare index holds no register.
    cfg_index <= CFG_SPARE;
    cfg_wdata <= CFG_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sends one contour; an open contour carries no last point and continues later.
  task automatic send_contour(input int npts, input contour_shape_t shape, input bit closed);
    int cx, cy, dx, dy, run, scale;
    cx = $urandom_range(2047);
    cy = $urandom_range(2047);
    dx = 0;
    dy = 0;
    run = 0;
    case ($urandom_range(2))
      0:       scale = 1;
      1:       scale = 16;
      default: scale = 300;
    endcase
    for (int k = 0; k < npts; k++) begin
      if (shape == SHAPE_NOISE) begin
        cx = $urandom_range(2047);
        cy = $urandom_range(2047);
      end else if (shape == SHAPE_PATH) begin
        // Straight runs with a new heading now and then.
        if (run == 0) begin
          dx = $urandom_range(8);
          dx = (dx - 4) * scale;
          dy = $urandom_range(8);
          dy = (dy - 4) * scale;
          run = $urandom_range(10, 1);
        end
        run--;
        cx = (cx + dx) & 2047;
        cy = (cy + dy) & 2047;
      end
      send_point(cx, cy, closed && (k == npts - 1));
    end
  endtask

  initial begin : stimulus
    int unsigned    cos_pick, minl_pick, win_pick, r;
    int             phase, runs, npts, random_end;
    contour_shape_t shape;
    board = new();
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_COS_SQ;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.point_x    <= '0;
    in_ch.point_y    <= '0;
    in_ch.last_point <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults; one- and two-point contours report nothing.
    send_point(100, 100, 1'b1);
    send_point(3, 4, 1'b0);
    send_point(2047, 0, 1'b1);

    // Right angle on the final point: a break and the closing segment from one word.
    program_regs(17'd49152, 13'd0, 5'd1);
    send_point(0, 0, 1'b0);
    send_point(5, 0, 1'b0);
    send_point(5, 5, 1'b1);

    // Coordinate extremes, a reversal and a sharp turn; a window of zero acts as one.
    program_regs(17'd65536, 13'd1, 5'd0);
    send_point(0, 0, 1'b0);
    send_point(2047, 2047, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(2047, 0, 1'b1);

    // Zero-length vectors break with any nonzero threshold.
    program_regs(17'd1, 13'd0, 5'd1);
    repeat (3) send_point(7, 7, 1'b0);
    send_point(7, 7, 1'b1);

    // A zero threshold disables breaks.
    program_regs(17'd0, 13'd0, 5'd1);
    repeat (2) send_point(7, 7, 1'b0);
    send_point(7, 7, 1'b1);

    // A threshold above one breaks even on a straight line.
    program_regs(17'd131071, 13'd0, 5'd1);
    send_point(0, 0, 1'b0);
    send_point(1, 0, 1'b0);
    send_point(2, 0, 1'b0);
    send_point(3, 0, 1'b1);

    // Random phases; some end inside a contour, so settings change mid-contour.
    random_end = points_sent + RANDOM_POINTS;
    phase = 0;
    while (points_sent < random_end) begin
      case ($urandom_range(5))
        0:       cos_pick = 0;
        1:       cos_pick = 65536;
        2:       cos_pick = $urandom_range(131071, 65537);
        3:       cos_pick = 49152;
        default: cos_pick = $urandom_range(65535);
      endcase
      case ($urandom_range(9))
        0:       minl_pick = 4096;
        1:       minl_pick = $urandom_range(8191, 4097);
        default: minl_pick = $urandom_range(12);
      endcase
      case ($urandom_range(7))
        0:       win_pick = 0;
        1:       win_pick = $urandom_range(31, 16);
        default: win_pick = $urandom_range(6, 1);
      endcase
      // The first phase has every corner report while the sink holds off for a long time.
      if (phase == 0) begin
        cos_pick  = 131071;
        minl_pick = 0;
      end
      program_regs(cos_pick[16:0], minl_pick[12:0], win_pick[4:0]);
      if (phase == 0) begin
        hold_left = HOLD_CYCLES;
      end
      runs = $urandom_range(6, 1);
      for (int k = 0; k < runs; k++) begin
        npts = ($urandom_range(8) == 0) ? $urandom_range(120, 34) : $urandom_range(40, 1);
        if (phase == 0 && k == 0) npts = 60;
        r = $urandom_range(9);
        shape = (r < 7) ? SHAPE_PATH : (r < 9) ? SHAPE_NOISE : SHAPE_STILL;
        send_contour(npts, shape, (k != runs - 1) || ($urandom_range(3) != 0));
      end
      phase++;
    end

    // A stretch with no idling on either side: still points break everywhere.
    program_regs(17'd1, 13'd0, 5'd1);
    idle_on = 1'b0;
    send_contour(STILL_POINTS, SHAPE_STILL, 1'b1);

    settle();
    if (board.err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ccs_pkg.sv
hw/rtl/ccs_if.sv
hw/rtl/ccs_ctrl.sv
hw/rtl/ccs_datapath.sv
hw/rtl/contour_corner_splitter.sv
tb/tb.sv
